// File: src/skt_pkg.sv
// ---------------------------------------------------------------------------
// skt_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted key tree lookup block.
// ---------------------------------------------------------------------------
package skt_pkg;

	localparam int TREE_LEVELS_DEF  = 6;
	localparam int MAX_ENTRIES_DEF  = 63;
	localparam int KEY_BYTES_DEF    = 8;
	localparam int HANDLER_BITS_DEF = 8;

	localparam int KEY_W        = 64;
	localparam int FUNC_W       = 2;
	localparam int HANDLER_W    = 8;
	localparam int STATUS_W     = 2;
	localparam int SLOT_LIMIT_W = 6;

	localparam logic [SLOT_LIMIT_W-1:0] SLOT_LIMIT_RST = 6'd63;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_BUILD  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

	typedef struct packed {
		logic latch;
		logic clear_list;
		logic load;
		logic refuse;
		logic sort_init;
		logic rd_i;
		logic cap_i;
		logic scan;
		logic wr_i;
		logic wr_m;
		logic place_init;
		logic place_rd;
		logic place_pop;
		logic place_wr;
		logic look_start;
		logic look_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              over_limit;
		logic              n_ge2;
		logic              j_lt_n;
		logic              more_sort;
		logic              place_ok;
		logic              stack_empty;
		logic              look_done;
		logic              out_free;
	} stat_t;

endpackage

// File: src/skt_ram.sv
// ---------------------------------------------------------------------------
// skt_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/skt_ctrl.sv
// ---------------------------------------------------------------------------
// skt_ctrl
// Sequencer for clear, load, build (selection sort then tree placement) and
// lookup transactions.
// ---------------------------------------------------------------------------
module skt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  skt_pkg::stat_t stat,
	output skt_pkg::cmd_t  cmd
);

	typedef enum logic [12:0] {
		S_IDLE       = 13'b0000000000001,
		S_EXEC       = 13'b0000000000010,
		S_SORT_RD_I  = 13'b0000000000100,
		S_SORT_CAP_I = 13'b0000000001000,
		S_SORT_SCAN  = 13'b0000000010000,
		S_SORT_WR_I  = 13'b0000000100000,
		S_SORT_WR_M  = 13'b0000001000000,
		S_PLACE_INIT = 13'b0000010000000,
		S_PLACE_TEST = 13'b0000100000000,
		S_PLACE_WR   = 13'b0001000000000,
		S_LOOK_START = 13'b0010000000000,
		S_LOOK_WALK  = 13'b0100000000000,
		S_FIN        = 13'b1000000000000
	} state_t;

	state_t state_q, state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.func)
					skt_pkg::FUNC_CLEAR: begin
						cmd.clear_list = 1'b1;
						state_nxt      = S_FIN;
					end
					skt_pkg::FUNC_LOAD: begin
						cmd.load  = 1'b1;
						state_nxt = S_FIN;
					end
					skt_pkg::FUNC_BUILD: begin
						if (stat.over_limit) begin
							cmd.refuse = 1'b1;
							state_nxt  = S_FIN;
						end else if (stat.n_ge2) begin
							cmd.sort_init = 1'b1;
							state_nxt     = S_SORT_RD_I;
						end else begin
							state_nxt = S_PLACE_INIT;
						end
					end
					default: begin
						state_nxt = S_LOOK_START;
					end
				endcase
			end
			S_SORT_RD_I: begin
				cmd.rd_i  = 1'b1;
				state_nxt = S_SORT_CAP_I;
			end
			S_SORT_CAP_I: begin
				cmd.cap_i = 1'b1;
				state_nxt = stat.j_lt_n ? S_SORT_SCAN : S_SORT_WR_I;
			end
			S_SORT_SCAN: begin
				cmd.scan = 1'b1;
				if (!stat.j_lt_n) begin
					state_nxt = S_SORT_WR_I;
				end
			end
			S_SORT_WR_I: begin
				cmd.wr_i  = 1'b1;
				state_nxt = S_SORT_WR_M;
			end
			S_SORT_WR_M: begin
				cmd.wr_m  = 1'b1;
				state_nxt = stat.more_sort ? S_SORT_RD_I : S_PLACE_INIT;
			end
			S_PLACE_INIT: begin
				cmd.place_init = 1'b1;
				state_nxt      = S_PLACE_TEST;
			end
			S_PLACE_TEST: begin
				if (stat.place_ok) begin
					cmd.place_rd = 1'b1;
					state_nxt    = S_PLACE_WR;
				end else if (!stat.stack_empty) begin
					cmd.place_pop = 1'b1;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_PLACE_WR: begin
				cmd.place_wr = 1'b1;
				state_nxt    = S_PLACE_TEST;
			end
			S_LOOK_START: begin
				cmd.look_start = 1'b1;
				state_nxt      = S_LOOK_WALK;
			end
			S_LOOK_WALK: begin
				cmd.look_step = 1'b1;
				if (stat.look_done) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: src/skt_dp.sv
// ---------------------------------------------------------------------------
// skt_dp
// Datapath: load list and tree memories, sort and placement registers,
// lookup walk, result and output registers, slot limit register.
// ---------------------------------------------------------------------------
module skt_dp #(
	parameter int TREE_LEVELS  = skt_pkg::TREE_LEVELS_DEF,
	parameter int MAX_ENTRIES  = skt_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BYTES    = skt_pkg::KEY_BYTES_DEF,
	parameter int HANDLER_BITS = skt_pkg::HANDLER_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  skt_pkg::cmd_t                      cmd,
	output skt_pkg::stat_t                     stat,
	input  logic [skt_pkg::FUNC_W-1:0]         func,
	input  logic [skt_pkg::KEY_W-1:0]          key,
	input  logic [skt_pkg::HANDLER_W-1:0]      handler_id,
	input  logic                               cfg_valid,
	input  logic [skt_pkg::SLOT_LIMIT_W-1:0]   cfg_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic                               found,
	output logic [skt_pkg::HANDLER_W-1:0]      match_handler,
	output logic [skt_pkg::STATUS_W-1:0]       status
);

	localparam int KW     = 8 * KEY_BYTES;
	localparam int HB     = HANDLER_BITS;
	localparam int EW     = KW + HB;
	localparam int CW     = $clog2(MAX_ENTRIES + 1);
	localparam int LAW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int TSLOTS = (1 << TREE_LEVELS) - 1;
	localparam int TAW    = TREE_LEVELS;
	localparam int SW     = TREE_LEVELS + 1;
	localparam int SPW    = $clog2(TREE_LEVELS + 1);
	localparam int SIW    = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

	// latched transaction
	logic [skt_pkg::FUNC_W-1:0] func_q;
	logic [KW-1:0]              key_q;
	logic [HB-1:0]              hid_q;

	logic [CW-1:0]                     cnt_q;
	logic [skt_pkg::SLOT_LIMIT_W-1:0]  slot_limit_q;

	logic                              res_found_q;
	logic [skt_pkg::HANDLER_W-1:0]     res_handler_q;
	logic [skt_pkg::STATUS_W-1:0]      res_status_q;

	logic                              out_valid_q;
	logic                              found_q;
	logic [skt_pkg::HANDLER_W-1:0]     match_handler_q;
	logic [skt_pkg::STATUS_W-1:0]      status_q;

	// sort registers
	logic [CW-1:0] i_q, j_q, m_q;
	logic [KW-1:0] min_key_q, tk_q;
	logic [HB-1:0] min_hdl_q, th_q;

	// placement and walk registers
	logic [CW-1:0]      lo_q, hi_q, mid_q;
	logic [SW-1:0]      idx_q;
	logic [SPW-1:0]     sp_q;
	logic [CW-1:0]      lo_stk_q  [TREE_LEVELS];
	logic [CW-1:0]      hi_stk_q  [TREE_LEVELS];
	logic [SW-1:0]      idx_stk_q [TREE_LEVELS];
	logic [TSLOTS-1:0]  valid_q;

	// memories
	logic           l_we;
	logic [LAW-1:0] l_waddr, l_raddr;
	logic [EW-1:0]  l_wdata, l_rdata;
	logic [TAW-1:0] t_raddr;
	logic [EW-1:0]  t_rdata;

	logic [15:0]   lim16;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic          in_rng, vbit, t_eq, t_gt;
	logic [SW-1:0] next_idx;
	logic [KW-1:0] l_key, t_key;
	logic [HB-1:0] l_hdl, t_hdl;
	logic [SIW-1:0] push_ix, pop_ix;
	logic [SPW-1:0] sp_dec;
	logic          out_free;

	assign l_key = l_rdata[EW-1:HB];
	assign l_hdl = l_rdata[HB-1:0];
	assign t_key = t_rdata[EW-1:HB];
	assign t_hdl = t_rdata[HB-1:0];

	assign lim16 = (16'(slot_limit_q) < 16'(TSLOTS)) ? 16'(slot_limit_q) : 16'(TSLOTS);

	assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q) - (CW+1)'(1);
	assign mid     = mid_sum[CW:1];

	assign in_rng   = (16'(idx_q) < lim16);
	assign vbit     = in_rng & valid_q[idx_q[TAW-1:0]];
	assign t_eq     = (t_key == key_q);
	assign t_gt     = (t_key > key_q);
	assign next_idx = (idx_q << 1) + (t_gt ? SW'(1) : SW'(2));

	assign sp_dec  = sp_q - SPW'(1);
	assign push_ix = sp_q[SIW-1:0];
	assign pop_ix  = sp_dec[SIW-1:0];

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		stat             = '0;
		stat.func        = func_q;
		stat.over_limit  = (16'(cnt_q) > 16'(slot_limit_q));
		stat.n_ge2       = (16'(cnt_q) >= 16'd2);
		stat.j_lt_n      = (j_q < cnt_q);
		stat.more_sort   = ((16'(i_q) + 16'd2) < 16'(cnt_q));
		stat.place_ok    = (lo_q < hi_q) && in_rng;
		stat.stack_empty = (sp_q == '0);
		stat.look_done   = !vbit || t_eq;
		stat.out_free    = out_free;
	end

	// load list port selection
	always_comb begin
		l_we    = 1'b0;
		l_waddr = cnt_q[LAW-1:0];
		l_wdata = {key_q, hid_q};
		if (cmd.load) begin
			l_we = (16'(cnt_q) < 16'(MAX_ENTRIES));
		end else if (cmd.wr_i) begin
			l_we    = 1'b1;
			l_waddr = i_q[LAW-1:0];
			l_wdata = {min_key_q, min_hdl_q};
		end else if (cmd.wr_m) begin
			l_we    = 1'b1;
			l_waddr = m_q[LAW-1:0];
			l_wdata = {tk_q, th_q};
		end
		if (cmd.rd_i) begin
			l_raddr = i_q[LAW-1:0];
		end else if (cmd.place_rd) begin
			l_raddr = mid[LAW-1:0];
		end else begin
			l_raddr = j_q[LAW-1:0];
		end
	end

	assign t_raddr = cmd.look_start ? '0 : next_idx[TAW-1:0];

	skt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES), .AW(LAW)) u_load_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	skt_ram #(.WIDTH(EW), .DEPTH(TSLOTS), .AW(TAW)) u_tree_ram (
		.clk   (clk),
		.we    (cmd.place_wr),
		.waddr (idx_q[TAW-1:0]),
		.wdata (l_rdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			slot_limit_q <= skt_pkg::SLOT_LIMIT_RST;
			valid_q      <= '0;
			sp_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				slot_limit_q <= cfg_data;
			end
			if (cmd.clear_list) begin
				cnt_q <= '0;
			end else if (cmd.load && (16'(cnt_q) < 16'(MAX_ENTRIES))) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.place_init) begin
				valid_q <= '0;
				sp_q    <= '0;
			end else if (cmd.place_wr) begin
				valid_q[idx_q[TAW-1:0]] <= 1'b1;
				sp_q                    <= sp_q + SPW'(1);
			end else if (cmd.place_pop) begin
				sp_q <= sp_dec;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q        <= func;
			key_q         <= key[skt_pkg::KEY_W-1 -: KW];
			hid_q         <= HB'(16'(handler_id));
			res_found_q   <= 1'b0;
			res_handler_q <= '0;
			res_status_q  <= skt_pkg::STATUS_OK;
		end
		if (cmd.load && !(16'(cnt_q) < 16'(MAX_ENTRIES))) begin
			res_status_q <= skt_pkg::STATUS_FULL;
		end
		if (cmd.refuse) begin
			res_status_q <= skt_pkg::STATUS_OVER;
		end

		if (cmd.sort_init) begin
			i_q <= '0;
		end
		if (cmd.rd_i) begin
			j_q <= i_q + CW'(1);
		end
		if (cmd.cap_i) begin
			min_key_q <= l_key;
			min_hdl_q <= l_hdl;
			tk_q      <= l_key;
			th_q      <= l_hdl;
			m_q       <= i_q;
		end
		if (cmd.scan && (l_key < min_key_q)) begin
			min_key_q <= l_key;
			min_hdl_q <= l_hdl;
			m_q       <= j_q - CW'(1);
		end
		// the next scan read is issued as the current one is taken in
		if ((cmd.cap_i || cmd.scan) && (j_q < cnt_q)) begin
			j_q <= j_q + CW'(1);
		end
		if (cmd.wr_m) begin
			i_q <= i_q + CW'(1);
		end

		if (cmd.place_init) begin
			lo_q  <= '0;
			hi_q  <= cnt_q;
			idx_q <= '0;
		end
		if (cmd.place_rd) begin
			mid_q <= mid;
		end
		if (cmd.place_wr) begin
			lo_stk_q[push_ix]  <= mid_q + CW'(1);
			hi_stk_q[push_ix]  <= hi_q;
			idx_stk_q[push_ix] <= (idx_q << 1) + SW'(2);
			hi_q               <= mid_q;
			idx_q              <= (idx_q << 1) + SW'(1);
		end
		if (cmd.place_pop) begin
			lo_q  <= lo_stk_q[pop_ix];
			hi_q  <= hi_stk_q[pop_ix];
			idx_q <= idx_stk_q[pop_ix];
		end

		if (cmd.look_start) begin
			idx_q <= '0;
		end
		if (cmd.look_step && vbit) begin
			if (t_eq) begin
				res_found_q   <= 1'b1;
				res_handler_q <= skt_pkg::HANDLER_W'(16'(t_hdl));
			end else begin
				idx_q <= next_idx;
			end
		end

		if (cmd.fin) begin
			found_q         <= res_found_q;
			match_handler_q <= res_handler_q;
			status_q        <= res_status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign match_handler = match_handler_q;
	assign status        = status_q;

endmodule

// File: src/sorted_key_tree_lookup_top.sv
// ---------------------------------------------------------------------------
// sorted_key_tree_lookup_top
// Route table keyed by names, searched as a balanced tree in implicit layout.
// ---------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries func, key, handler_id; one
//   transaction is worked on at a time and gives exactly one result on the
//   out_valid/out_ready channel (found, match_handler, status).
//   cfg_valid/cfg_ready writes slot_limit; cfg_ready is always high, write
//   only while no transaction is in flight.
// steps (input accept to result valid):
//   clear and load: execute state, then result state
//   lookup: start state, then one walk step per tree slot examined, counting the
//   empty or out of range slot that ends a miss; the walk makes one tree
//   memory read per level
//   build: selection sort of the loaded entries through the one read port
//   of the load list memory, then tree placement
// a new transaction is taken as soon as the previous result sits in the
// output register; a stalled receiver holds the result, and the next
// result waits in the block until the output register is free.
// reset clears the load count, every tree valid bit and the output valid,
// and sets slot_limit to 63; no memory clearing pass is needed.
// ---------------------------------------------------------------------------
module sorted_key_tree_lookup_top #(
	parameter int TREE_LEVELS  = skt_pkg::TREE_LEVELS_DEF,
	parameter int MAX_ENTRIES  = skt_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BYTES    = skt_pkg::KEY_BYTES_DEF,
	parameter int HANDLER_BITS = skt_pkg::HANDLER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [skt_pkg::FUNC_W-1:0]        func,
	input  logic [skt_pkg::KEY_W-1:0]         key,
	input  logic [skt_pkg::HANDLER_W-1:0]     handler_id,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [skt_pkg::HANDLER_W-1:0]     match_handler,
	output logic [skt_pkg::STATUS_W-1:0]      status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [skt_pkg::SLOT_LIMIT_W-1:0]  cfg_data
);

	skt_pkg::cmd_t  cmd;
	skt_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	skt_dp #(
		.TREE_LEVELS  (TREE_LEVELS),
		.MAX_ENTRIES  (MAX_ENTRIES),
		.KEY_BYTES    (KEY_BYTES),
		.HANDLER_BITS (HANDLER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.key           (key),
		.handler_id    (handler_id),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.found         (found),
		.match_handler (match_handler),
		.status        (status)
	);

endmodule

// File: src/skt_checker.sv
// ---------------------------------------------------------------------------
// skt_checker
// Port-level checks for the sorted key tree lookup block, bound to the top.
// ---------------------------------------------------------------------------
module skt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              found,
	input logic [skt_pkg::HANDLER_W-1:0]     match_handler,
	input logic [skt_pkg::STATUS_W-1:0]      status
);

	// one transaction in flight: input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	a_miss_zero_handler: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (match_handler == '0))
		else $error("handler reported without a match");

	a_hit_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (status == skt_pkg::STATUS_OK))
		else $error("match reported with error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == skt_pkg::STATUS_OK || status == skt_pkg::STATUS_FULL
			|| status == skt_pkg::STATUS_OVER))
		else $error("status code out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(found)
			&& $stable(match_handler) && $stable(status)))
		else $error("result changed while stalled");

endmodule

bind sorted_key_tree_lookup_top skt_checker u_skt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.found         (found),
	.match_handler (match_handler),
	.status        (status)
);

// File: bench/tb_sorted_key_tree_lookup_top.sv
// ---------------------------------------------------------------------------
// tb_sorted_key_tree_lookup_top
// Self-checking bench for the route table: a route table model predicts
// every result, which is then compared field by field with the block's output
// under random idling on both channels and several slot limit settings.
// ---------------------------------------------------------------------------
module tb_sorted_key_tree_lookup_top;
	import skt_pkg::*;

	localparam int SLOTS = 63;
	localparam int LOAD_DEPTH = 63;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic                found;
		logic [HANDLER_W-1:0] handler;
		logic [STATUS_W-1:0]  status;
	} route_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [FUNC_W-1:0]        func;
	logic [KEY_W-1:0]         key;
	logic [HANDLER_W-1:0]     handler_id;
	logic                     out_valid;
	logic                     out_ready;
	logic                     found;
	logic [HANDLER_W-1:0]     match_handler;
	logic [STATUS_W-1:0]      status;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [SLOT_LIMIT_W-1:0]  cfg_data;

	// route table model
	logic [KEY_W-1:0]         list_keys [LOAD_DEPTH];
	logic [HANDLER_W-1:0]     list_handlers [LOAD_DEPTH];
	int                       list_count;
	logic [KEY_W-1:0]         node_keys [SLOTS];
	logic [HANDLER_W-1:0]     node_handlers [SLOTS];
	logic                     node_valid [SLOTS];
	int                       slot_limit;

	route_result_t            pending_results [$];
	int                       fail_count;
	int                       items_sent;
	int                       cycle_count;
	bit                       quiet;
	int                       stall_left;
	int                       gap_left;

	sorted_key_tree_lookup_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.key          (key),
		.handler_id   (handler_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_handler(match_handler),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void place_range(int lo, int hi, int slot, int lim);
		int mid;
		if (lo >= hi || slot >= lim)
			return;
		mid = (lo + hi - 1) / 2;
		node_keys[slot] = list_keys[mid];
		node_handlers[slot] = list_handlers[mid];
		node_valid[slot] = 1'b1;
		place_range(lo, mid, 2 * slot + 1, lim);
		place_range(mid + 1, hi, 2 * slot + 2, lim);
	endfunction

	function automatic void build_table();
		int m;
		logic [KEY_W-1:0] tk;
		logic [HANDLER_W-1:0] th;
		for (int i = 0; i + 1 < list_count; i++) begin
			m = i;
			for (int j = i + 1; j < list_count; j++)
				if (list_keys[j] < list_keys[m])
					m = j;
			tk = list_keys[i];
			th = list_handlers[i];
			list_keys[i] = list_keys[m];
			list_handlers[i] = list_handlers[m];
			list_keys[m] = tk;
			list_handlers[m] = th;
		end
		for (int s = 0; s < SLOTS; s++)
			node_valid[s] = 1'b0;
		place_range(0, list_count, 0, (slot_limit < SLOTS) ? slot_limit : SLOTS);
	endfunction

	function automatic route_result_t route_apply(logic [FUNC_W-1:0] f,
			logic [KEY_W-1:0] k, logic [HANDLER_W-1:0] h);
		route_result_t r;
		int lim;
		int idx;
		r = '0;
		case (f)
			FUNC_CLEAR: begin
				list_count = 0;
			end
			FUNC_LOAD: begin
				if (list_count >= LOAD_DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					list_keys[list_count] = k;
					list_handlers[list_count] = h;
					list_count++;
				end
			end
			FUNC_BUILD: begin
				if (list_count > slot_limit)
					r.status = STATUS_OVER;
				else
					build_table();
			end
			default: begin
				lim = (slot_limit < SLOTS) ? slot_limit : SLOTS;
				idx = 0;
				while (idx < lim && node_valid[idx]) begin
					if (node_keys[idx] > k) begin
						idx = 2 * idx + 1;
					end else if (node_keys[idx] < k) begin
						idx = 2 * idx + 2;
					end else begin
						r.found = 1'b1;
						r.handler = node_handlers[idx];
						break;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_item(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
			logic [HANDLER_W-1:0] h);
		@(negedge clk);
		if (!quiet && gap_left == 0 && $urandom_range(0, 7) == 0)
			gap_left = $urandom_range(1, 7);
		if (gap_left > 0) begin
			in_valid = 1'b0;
			while (gap_left > 0) begin
				gap_left--;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		func = f;
		key = k;
		handler_id = h;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(route_apply(f, k, h));
		items_sent++;
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_slot_limit(int v);
		wait_results_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v[SLOT_LIMIT_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		slot_limit = v & 63;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] any_key();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return KEY_W'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_basic_ops();
		send_item(FUNC_LOOKUP, '0, 8'h00);
		send_item(FUNC_BUILD, '0, 8'h00);
		send_item(FUNC_LOOKUP, '1, 8'hff);
		send_item(FUNC_LOAD, '1, 8'hff);
		send_item(FUNC_LOAD, '0, 8'h00);
		send_item(FUNC_LOAD, 64'h6170_6900_0000_0000, 8'h5a);
		send_item(FUNC_LOAD, 64'h6170_6900_0000_0000, 8'ha5);
		send_item(FUNC_LOAD, 64'h8000_0000_0000_0001, 8'h11);
		send_item(FUNC_BUILD, '0, 8'h00);
		send_item(FUNC_LOOKUP, '1, 8'h00);
		send_item(FUNC_LOOKUP, '0, 8'h00);
		// equal keys: first on the path wins
		send_item(FUNC_LOOKUP, 64'h6170_6900_0000_0000, 8'h00);
		send_item(FUNC_LOOKUP, 64'h8000_0000_0000_0001, 8'h00);
		send_item(FUNC_LOOKUP, 64'h8000_0000_0000_0000, 8'h00);
		send_item(FUNC_CLEAR, '1, 8'hff);
		send_item(FUNC_BUILD, '0, 8'h00);
		send_item(FUNC_LOOKUP, '1, 8'h00);
	endtask

	task automatic test_list_full();
		send_item(FUNC_CLEAR, '0, 8'h00);
		for (int i = 0; i < LOAD_DEPTH + 2; i++)
			send_item(FUNC_LOAD, {$urandom, $urandom}, 8'($urandom));
		send_item(FUNC_BUILD, '0, 8'h00);
		for (int i = 0; i < 4; i++)
			send_item(FUNC_LOOKUP, list_keys[$urandom_range(0, LOAD_DEPTH - 1)], 8'h00);
	endtask

	task automatic test_slot_limit_edges();
		write_slot_limit(0);
		send_item(FUNC_BUILD, '0, 8'h00);
		send_item(FUNC_LOOKUP, list_keys[0], 8'h00);
		send_item(FUNC_CLEAR, '0, 8'h00);
		send_item(FUNC_BUILD, '0, 8'h00);
		send_item(FUNC_LOOKUP, '0, 8'h00);
		// five entries under a limit of five leave one entry on an out of range slot
		write_slot_limit(5);
		for (int i = 0; i < 5; i++)
			send_item(FUNC_LOAD, KEY_W'(10 * i + 10), 8'(i + 1));
		send_item(FUNC_BUILD, '0, 8'h00);
		for (int i = 0; i < 5; i++)
			send_item(FUNC_LOOKUP, KEY_W'(10 * i + 10), 8'h00);
		send_item(FUNC_LOAD, 64'd99, 8'h77);
		send_item(FUNC_BUILD, '0, 8'h00);
		write_slot_limit(1);
		send_item(FUNC_CLEAR, '0, 8'h00);
		send_item(FUNC_LOAD, 64'd7, 8'h42);
		send_item(FUNC_BUILD, '0, 8'h00);
		send_item(FUNC_LOOKUP, 64'd7, 8'h00);
	endtask

	task automatic test_random_traffic(int target);
		logic [KEY_W-1:0] pool [8];
		logic [KEY_W-1:0] k;
		int n;
		int seq;
		int limits [4];
		limits = '{1, 63, 7, 15};
		seq = 0;
		while (items_sent < target) begin
			if (items_sent > target - 150)
				quiet = 1'b1;
			if (seq % 6 == 5) begin
				if ($urandom_range(0, 1))
					write_slot_limit(limits[$urandom_range(0, 3)]);
				else
					write_slot_limit($urandom_range(1, 63));
			end
			if (seq % 9 == 4)
				wait_results_drained();
			seq++;
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 6))
					send_item(FUNC_W'($urandom_range(0, 3)), any_key(), 8'($urandom));
				continue;
			end
			for (int i = 0; i < 8; i++)
				pool[i] = any_key();
			case ($urandom_range(0, 19))
				0: n = $urandom_range(20, 63);
				1: n = slot_limit + 1;
				default: n = $urandom_range(1, 8);
			endcase
			send_item(FUNC_CLEAR, any_key(), 8'($urandom));
			for (int i = 0; i < n; i++) begin
				k = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : any_key();
				send_item(FUNC_LOAD, k, 8'($urandom));
			end
			send_item(FUNC_BUILD, any_key(), 8'($urandom));
			repeat ($urandom_range(4, 12)) begin
				case ($urandom_range(0, 4))
					0, 1: k = list_keys[$urandom_range(0, (n < LOAD_DEPTH ? n : LOAD_DEPTH) - 1)];
					2: k = pool[$urandom_range(0, 7)] + KEY_W'($urandom_range(0, 2)) - 1;
					default: k = any_key();
				endcase
				send_item(FUNC_LOOKUP, k, 8'($urandom));
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		route_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation waiting");
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (found !== exp_r.found) begin
					$error("found: expected %0d, actual %0d", exp_r.found, found);
					fail_count++;
				end
				if (match_handler !== exp_r.handler) begin
					$error("match_handler: expected %0d, actual %0d", exp_r.handler,
						match_handler);
					fail_count++;
				end
				if (status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, status);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (quiet) begin
			out_ready = 1'b1;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_ready = 1'b0;
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_CLEAR;
		key = '0;
		handler_id = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		fail_count = 0;
		items_sent = 0;
		cycle_count = 0;
		quiet = 1'b0;
		stall_left = 0;
		gap_left = 0;
		list_count = 0;
		slot_limit = 63;
		for (int s = 0; s < SLOTS; s++)
			node_valid[s] = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_basic_ops();
		test_list_full();
		test_slot_limit_edges();
		write_slot_limit(63);
		test_random_traffic(1250);

		wait_results_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			if (pending_results.size() != 0)
				$error("%0d expected results never arrived", pending_results.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/skt_pkg.sv
src/skt_ram.sv
src/skt_ctrl.sv
src/skt_dp.sv
src/sorted_key_tree_lookup_top.sv
src/skt_checker.sv
bench/tb_sorted_key_tree_lookup_top.sv
